[src/peak_trough_detector_macros.svh]
// assertion macros for the peak and trough detector
`ifndef PEAK_TROUGH_DETECTOR_MACROS_SVH
`define PEAK_TROUGH_DETECTOR_MACROS_SVH

// same-cycle implication, checked on the rising edge of aclk outside reset
`define PTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on the rising edge of aclk outside reset
`define PTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ptd_pkg.sv]
// types and constants shared by the peak and trough detector
package ptd_pkg;

    // field widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int INDEX_WIDTH  = 16;
    localparam int THRESH_WIDTH = 16;

    // compare width: wide enough that sample plus threshold never overflows
    localparam int CMP_WIDTH =
        ((SAMPLE_WIDTH > THRESH_WIDTH) ? SAMPLE_WIDTH : THRESH_WIDTH) + 2;

    // stream widths, rounded up to whole bytes
    localparam int S_TDATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((2 * INDEX_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8;

    // threshold after reset
    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(2322);

    // saturation value of index and counts
    localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = '1;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic        [INDEX_WIDTH-1:0]  index_t;
    typedef logic signed [CMP_WIDTH-1:0]    cmp_t;

    // tracking direction
    typedef enum logic [1:0] {
        DIR_UNDECIDED = 2'd0,
        DIR_PEAK      = 2'd1,
        DIR_TROUGH    = 2'd2
    } dir_t;

    // event kind codes
    localparam logic KIND_PEAK   = 1'b0;
    localparam logic KIND_TROUGH = 1'b1;

    // saturating increment of an index or count
    function automatic index_t sat_inc(input index_t v);
        sat_inc = (v == INDEX_MAX) ? v : v + index_t'(1);
    endfunction

endpackage

[src/peak_trough_detector.sv]
// peak and trough detector with hysteresis over windows of signed samples
//
//   channel   ports                 payload
//   input     s_tvalid/s_tready     tdata: sample, tuser: window_start
//   output    m_tvalid/m_tready     tdata: index, value, number, tuser: kind
//   config    cfg_wr_en             cfg_wr_data: hysteresis threshold
//
// one item per cycle sustained unless a stalled result holds the flow; an item
// passes the input register, then compare-and-update into the result register.
// the tracking state updates in the same cycle the result register loads.
// synchronous active-low reset clears tracking, index and counts and reloads
// the default threshold.
// a stalled result holds the result register; the input register keeps one
// item, then s_tready drops until the result is taken.
module peak_trough_detector (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [ptd_pkg::THRESH_WIDTH-1:0]    cfg_wr_data,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ptd_pkg::S_TDATA_WIDTH-1:0]   s_tdata,   // [sample]
    input  logic [0:0]                          s_tuser,   // [window_start]
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ptd_pkg::M_TDATA_WIDTH-1:0]   m_tdata,   // [event_index, event_value, event_number]
    output logic [0:0]                          m_tuser    // [event_kind]
);

    // threshold register
    logic [ptd_pkg::THRESH_WIDTH-1:0] thresh_reg;

    // input stage
    logic             in_valid_reg;
    ptd_pkg::sample_t in_sample_reg;
    logic             in_start_reg;

    // tracking state
    ptd_pkg::dir_t    dir_reg,          dir_next;
    ptd_pkg::sample_t max_value_reg,    max_value_next;
    ptd_pkg::index_t  max_index_reg,    max_index_next;
    ptd_pkg::sample_t min_value_reg,    min_value_next;
    ptd_pkg::index_t  min_index_reg,    min_index_next;
    ptd_pkg::index_t  counter_reg,      counter_next;
    ptd_pkg::index_t  peak_count_reg,   peak_count_next;
    ptd_pkg::index_t  trough_count_reg, trough_count_next;

    // result register
    logic             out_valid_reg;
    logic             out_kind_reg,   out_kind_next;
    ptd_pkg::index_t  out_index_reg,  out_index_next;
    ptd_pkg::sample_t out_value_reg,  out_value_next;
    ptd_pkg::index_t  out_number_reg, out_number_next;

    logic fire;
    logic event_hit;
    logic s_accept;

    // compare stage advances when the result register is free or being drained
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    // threshold write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= ptd_pkg::THRESH_RESET;
        end else if (cfg_wr_en) begin
            thresh_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_sample_reg <= ptd_pkg::sample_t'(s_tdata[ptd_pkg::SAMPLE_WIDTH-1:0]);
            in_start_reg  <= s_tuser[0];
        end
    end

    // compare and update
    always_comb begin
        ptd_pkg::dir_t    dir_w;
        ptd_pkg::sample_t max_w;
        ptd_pkg::index_t  max_i_w;
        ptd_pkg::sample_t min_w;
        ptd_pkg::index_t  min_i_w;
        ptd_pkg::index_t  pk_w;
        ptd_pkg::index_t  tr_w;
        ptd_pkg::index_t  idx;
        ptd_pkg::cmp_t    s_c;
        ptd_pkg::cmp_t    e_c;
        ptd_pkg::cmp_t    max_c;
        ptd_pkg::cmp_t    min_c;

        dir_w   = dir_reg;
        max_w   = max_value_reg;
        max_i_w = max_index_reg;
        min_w   = min_value_reg;
        min_i_w = min_index_reg;
        pk_w    = peak_count_reg;
        tr_w    = trough_count_reg;
        idx     = ptd_pkg::sat_inc(counter_reg);

        // window start clears tracking, this sample is index zero
        if (in_start_reg) begin
            dir_w   = ptd_pkg::DIR_UNDECIDED;
            max_w   = in_sample_reg;
            min_w   = in_sample_reg;
            max_i_w = '0;
            min_i_w = '0;
            pk_w    = '0;
            tr_w    = '0;
            idx     = '0;
        end

        s_c   = ptd_pkg::CMP_WIDTH'(in_sample_reg);
        e_c   = ptd_pkg::cmp_t'(ptd_pkg::CMP_WIDTH'(thresh_reg));
        max_c = ptd_pkg::CMP_WIDTH'(max_w);
        min_c = ptd_pkg::CMP_WIDTH'(min_w);

        event_hit       = 1'b0;
        out_kind_next   = ptd_pkg::KIND_PEAK;
        out_index_next  = max_i_w;
        out_value_next  = max_w;
        out_number_next = pk_w;

        case (dir_w)
            ptd_pkg::DIR_PEAK: begin
                if (max_c <= s_c) begin
                    max_w   = in_sample_reg;
                    max_i_w = idx;
                end else if (max_c >= s_c + e_c) begin
                    // confirmed peak, start seeking a trough from here
                    pk_w            = ptd_pkg::sat_inc(pk_w);
                    event_hit       = 1'b1;
                    out_kind_next   = ptd_pkg::KIND_PEAK;
                    out_index_next  = max_i_w;
                    out_value_next  = max_w;
                    out_number_next = pk_w;
                    min_w           = in_sample_reg;
                    min_i_w         = idx;
                    dir_w           = ptd_pkg::DIR_TROUGH;
                end
            end
            ptd_pkg::DIR_TROUGH: begin
                if (s_c <= min_c) begin
                    min_w   = in_sample_reg;
                    min_i_w = idx;
                end else if (s_c >= min_c + e_c) begin
                    // confirmed trough, start seeking a peak from here
                    tr_w            = ptd_pkg::sat_inc(tr_w);
                    event_hit       = 1'b1;
                    out_kind_next   = ptd_pkg::KIND_TROUGH;
                    out_index_next  = min_i_w;
                    out_value_next  = min_w;
                    out_number_next = tr_w;
                    max_w           = in_sample_reg;
                    max_i_w         = idx;
                    dir_w           = ptd_pkg::DIR_PEAK;
                end
            end
            default: begin
                // undecided: pick a direction, trough seeking wins
                if (max_c >= s_c + e_c) begin
                    dir_w = ptd_pkg::DIR_TROUGH;
                end else if (s_c >= min_c + e_c) begin
                    dir_w = ptd_pkg::DIR_PEAK;
                end
                if (max_c <= s_c) begin
                    max_w   = in_sample_reg;
                    max_i_w = idx;
                end else if (s_c <= min_c) begin
                    min_w   = in_sample_reg;
                    min_i_w = idx;
                end
            end
        endcase

        dir_next          = dir_w;
        max_value_next    = max_w;
        max_index_next    = max_i_w;
        min_value_next    = min_w;
        min_index_next    = min_i_w;
        counter_next      = idx;
        peak_count_next   = pk_w;
        trough_count_next = tr_w;
    end

    // tracking state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg          <= ptd_pkg::DIR_UNDECIDED;
            max_value_reg    <= '0;
            max_index_reg    <= '0;
            min_value_reg    <= '0;
            min_index_reg    <= '0;
            counter_reg      <= '0;
            peak_count_reg   <= '0;
            trough_count_reg <= '0;
        end else if (fire) begin
            dir_reg          <= dir_next;
            max_value_reg    <= max_value_next;
            max_index_reg    <= max_index_next;
            min_value_reg    <= min_value_next;
            min_index_reg    <= min_index_next;
            counter_reg      <= counter_next;
            peak_count_reg   <= peak_count_next;
            trough_count_reg <= trough_count_next;
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= event_hit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (fire && event_hit) begin
            out_kind_reg   <= out_kind_next;
            out_index_reg  <= out_index_next;
            out_value_reg  <= out_value_next;
            out_number_reg <= out_number_next;
        end
    end

    // output packing, index in the lowest bits
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = ptd_pkg::M_TDATA_WIDTH'({out_number_reg, out_value_reg, out_index_reg});
    assign m_tuser[0] = out_kind_reg;

    // checks
    `include "peak_trough_detector_macros.svh"

    `PTD_ASSERT_NEXT(a_event_shown, fire && event_hit, out_valid_reg,
        "event item not presented")
    `PTD_ASSERT_NEXT(a_peak_turns,
        fire && event_hit && (out_kind_next == ptd_pkg::KIND_PEAK),
        dir_reg == ptd_pkg::DIR_TROUGH, "no trough search after a peak")
    `PTD_ASSERT_NEXT(a_index_sat,
        fire && !in_start_reg && (counter_reg == ptd_pkg::INDEX_MAX),
        counter_reg == ptd_pkg::INDEX_MAX, "sample index wrapped")
    `PTD_ASSERT_NOW(a_stall_blocks, in_valid_reg && out_valid_reg && !m_tready,
        !s_tready, "input taken while both stages are full")

endmodule
